@@ hw/rtl/dam_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dam_pkg
// Shared types, constants and helpers for the DRAM address mapper: register
// codes, the piece layout of each mapping scheme and the stage structs.
// ----------------------------------------------------------------------------
package dam_pkg;

  localparam int DAM_ADDR_WIDTH = 64;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 5;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SCHEME_SELECT    = 3'd0,
    REG_CHANNEL_BITS     = 3'd1,
    REG_RANK_BITS        = 3'd2,
    REG_BANK_BITS        = 3'd3,
    REG_ROW_BITS         = 3'd4,
    REG_COLUMN_BITS      = 3'd5,
    REG_BYTE_OFFSET_BITS = 3'd6,
    REG_COLUMN_LOW_BITS  = 3'd7
  } cfg_reg_t;

  // Split interleave scheme code; all lower codes are plain field orders
  localparam logic [2:0] SCHEME_SPLIT = 3'd7;

  typedef struct packed {
    logic [2:0] scheme_select;
    logic [2:0] channel_bits;
    logic [2:0] rank_bits;
    logic [2:0] bank_bits;
    logic [4:0] row_bits;
    logic [4:0] column_bits;
    logic [2:0] byte_offset_bits;
    logic [2:0] column_low_bits;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    scheme_select:    3'd0,
    channel_bits:     3'd0,
    rank_bits:        3'd1,
    bank_bits:        3'd3,
    row_bits:         5'd14,
    column_bits:      5'd10,
    byte_offset_bits: 3'd3,
    column_low_bits:  3'd3
  };

  // Address pieces. Plain schemes use only the low piece of bank, row and
  // column; the split scheme uses all of them.
  localparam int NUM_PIECES = 9;
  localparam int PIECE_W    = 4;
  localparam int OFF_W      = 7;   // offsets up to 83
  localparam int WID_W      = 5;   // piece widths up to 31
  localparam int ALIGN_W    = 4;   // byte offset + burst bits, up to 14

  localparam logic [PIECE_W-1:0] P_CHAN    = 4'd0;
  localparam logic [PIECE_W-1:0] P_RANK    = 4'd1;
  localparam logic [PIECE_W-1:0] P_BANK_LO = 4'd2;
  localparam logic [PIECE_W-1:0] P_BANK_HI = 4'd3;
  localparam logic [PIECE_W-1:0] P_ROW_LO  = 4'd4;
  localparam logic [PIECE_W-1:0] P_ROW_HI  = 4'd5;
  localparam logic [PIECE_W-1:0] P_COL_LO  = 4'd6;
  localparam logic [PIECE_W-1:0] P_COL_MID = 4'd7;
  localparam logic [PIECE_W-1:0] P_COL_HI  = 4'd8;

  // Piece order from the low address end, one row per scheme. Plain rows
  // end with the pieces they leave at zero width.
  localparam logic [PIECE_W-1:0] PIECE_ORDER [8][NUM_PIECES] = '{
    '{P_BANK_LO, P_COL_LO,  P_ROW_LO,  P_RANK,    P_CHAN,
      P_BANK_HI, P_ROW_HI,  P_COL_MID, P_COL_HI},
    '{P_RANK,    P_BANK_LO, P_COL_LO,  P_ROW_LO,  P_CHAN,
      P_BANK_HI, P_ROW_HI,  P_COL_MID, P_COL_HI},
    '{P_ROW_LO,  P_COL_LO,  P_BANK_LO, P_RANK,    P_CHAN,
      P_BANK_HI, P_ROW_HI,  P_COL_MID, P_COL_HI},
    '{P_COL_LO,  P_ROW_LO,  P_BANK_LO, P_RANK,    P_CHAN,
      P_BANK_HI, P_ROW_HI,  P_COL_MID, P_COL_HI},
    '{P_BANK_LO, P_RANK,    P_COL_LO,  P_ROW_LO,  P_CHAN,
      P_BANK_HI, P_ROW_HI,  P_COL_MID, P_COL_HI},
    '{P_COL_LO,  P_RANK,    P_BANK_LO, P_ROW_LO,  P_CHAN,
      P_BANK_HI, P_ROW_HI,  P_COL_MID, P_COL_HI},
    '{P_CHAN,    P_BANK_LO, P_RANK,    P_COL_LO,  P_ROW_LO,
      P_BANK_HI, P_ROW_HI,  P_COL_MID, P_COL_HI},
    '{P_CHAN,    P_COL_LO,  P_RANK,    P_BANK_LO, P_COL_MID,
      P_ROW_LO,  P_BANK_HI, P_ROW_HI,  P_COL_HI}
  };

  // Where each piece sits in the working address
  typedef struct packed {
    logic [NUM_PIECES-1:0][OFF_W-1:0] off;
    logic [NUM_PIECES-1:0][WID_W-1:0] wid;
    logic [ALIGN_W-1:0]               align;
  } plan_t;

  // Extracted pieces, each cut to what survives in the outputs
  typedef struct packed {
    logic [3:0]  chan;
    logic [3:0]  rank;
    logic [3:0]  bank_lo;
    logic [2:0]  bank_hi;
    logic [19:0] row_lo;
    logic [15:0] row_hi;
    logic [15:0] col_lo;
    logic        col_mid;
    logic [8:0]  col_hi;
  } pieces_t;

  // Signed width to piece width; zero or negative gives zero
  function automatic logic [WID_W-1:0] clamp_width(logic signed [OFF_W-1:0] w);
    return w[OFF_W-1] ? '0 : w[WID_W-1:0];
  endfunction

endpackage

@@ hw/rtl/dram_address_mapper_core.sv @@
`timescale 1ns / 1ps
// Pipeline: the accepting edge loads the input register, then the alignment
//   shift, piece extraction and output assembly are each registered in turn.
// Throughput: one request per cycle while out_ready holds; stages advance
//   independently, so a stalled output only holds back the stages behind it.
// Reset: synchronous; clears all stage valid bits and loads the register
//   reset values. Register writes reach the mapping in the following cycle.
// ----------------------------------------------------------------------------
// dram_address_mapper_core
// Splits a byte address into channel, rank, bank, row and column under one
// of eight mapping schemes and flags addresses not aligned to a burst.
// ----------------------------------------------------------------------------
module dram_address_mapper_core #(
  parameter int ADDR_WIDTH = dam_pkg::DAM_ADDR_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_write_enable,
  input  logic [dam_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dam_pkg::CFG_DATA_W-1:0]  cfg_data,
  // request
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [63:0]                  physical_address,
  // result
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [3:0]                   channel,
  output logic [3:0]                   rank,
  output logic [3:0]                   bank,
  output logic [19:0]                  row,
  output logic [15:0]                  column,
  output logic                         unaligned
);
  import dam_pkg::*;

  localparam int XW = ADDR_WIDTH + 32;

  cfg_t  cfg;
  plan_t plan;

  logic                  v0, v1, v2;
  logic                  rdy1, rdy2, rdy3;
  logic [ADDR_WIDTH-1:0] addr0;
  logic [ADDR_WIDTH-1:0] work1, work1_next;
  logic                  unal1, unal1_next;
  logic                  unal2;
  pieces_t               pieces2, pieces2_next;

  // Cut one piece out of the working address, zero past its top
  function automatic logic [31:0] take_piece(logic [ADDR_WIDTH-1:0] w,
                                             logic [OFF_W-1:0] off,
                                             logic [WID_W-1:0] wid);
    logic [XW-1:0] ext;
    ext = {32'd0, w} >> off;
    return ext[31:0] & ~(32'hFFFF_FFFF << wid);
  endfunction

  // Mapping registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SCHEME_SELECT:    cfg.scheme_select    <= cfg_data[2:0];
        REG_CHANNEL_BITS:     cfg.channel_bits     <= cfg_data[2:0];
        REG_RANK_BITS:        cfg.rank_bits        <= cfg_data[2:0];
        REG_BANK_BITS:        cfg.bank_bits        <= cfg_data[2:0];
        REG_ROW_BITS:         cfg.row_bits         <= cfg_data;
        REG_COLUMN_BITS:      cfg.column_bits      <= cfg_data;
        REG_BYTE_OFFSET_BITS: cfg.byte_offset_bits <= cfg_data[2:0];
        REG_COLUMN_LOW_BITS:  cfg.column_low_bits  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  dam_plan u_plan (
    .clk  (clk),
    .cfg  (cfg),
    .plan (plan)
  );

  // Stage handshake: a stage moves when it is empty or its successor moves
  assign rdy3     = !out_valid || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = !v0 || rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) v0        <= in_valid;
      if (rdy1)     v1        <= v0;
      if (rdy2)     v2        <= v1;
      if (rdy3)     out_valid <= v2;
    end
  end

  // Stage 0: capture the request address
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) addr0 <= physical_address[ADDR_WIDTH-1:0];
  end

  // Stage 1: drop byte-offset and burst bits, check alignment
  always_comb begin
    work1_next = addr0 >> plan.align;
    unal1_next = |(addr0 & ~({ADDR_WIDTH{1'b1}} << plan.align));
  end

  always_ff @(posedge clk) begin
    if (rdy1 && v0) begin
      work1 <= work1_next;
      unal1 <= unal1_next;
    end
  end

  // Stage 2: extract all pieces in parallel
  always_comb begin
    logic [NUM_PIECES-1:0][31:0] raw;
    for (int i = 0; i < NUM_PIECES; i++) begin
      raw[i] = take_piece(work1, plan.off[i], plan.wid[i]);
    end
    pieces2_next.chan    = raw[P_CHAN][3:0];
    pieces2_next.rank    = raw[P_RANK][3:0];
    pieces2_next.bank_lo = raw[P_BANK_LO][3:0];
    pieces2_next.bank_hi = raw[P_BANK_HI][2:0];
    pieces2_next.row_lo  = raw[P_ROW_LO][19:0];
    pieces2_next.row_hi  = raw[P_ROW_HI][15:0];
    pieces2_next.col_lo  = raw[P_COL_LO][15:0];
    pieces2_next.col_mid = raw[P_COL_MID][0];
    pieces2_next.col_hi  = raw[P_COL_HI][8:0];
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      pieces2 <= pieces2_next;
      unal2   <= unal1;
    end
  end

  // Stage 3: merge pieces into the result fields
  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      channel   <= pieces2.chan;
      rank      <= pieces2.rank;
      bank      <= pieces2.bank_lo | {pieces2.bank_hi, 1'b0};
      row       <= pieces2.row_lo | {pieces2.row_hi, 4'b0000};
      column    <= pieces2.col_lo | {9'd0, pieces2.col_mid, 6'd0}
                   | {pieces2.col_hi, 7'd0};
      unaligned <= unal2;
    end
  end

endmodule

@@ hw/rtl/dam_plan.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dam_plan
// Turns the mapping registers into a registered table of piece offsets and
// widths, plus the alignment shift. Follows the registers in the next cycle.
// ----------------------------------------------------------------------------
module dam_plan (
  input  logic          clk,
  input  dam_pkg::cfg_t cfg,
  output dam_pkg::plan_t plan
);
  import dam_pkg::*;

  plan_t plan_next;

  // Piece widths per scheme, then offsets as a running sum along the order
  always_comb begin
    logic signed [OFF_W-1:0]       wcol;
    logic [NUM_PIECES-1:0][WID_W-1:0] wid;
    logic [OFF_W-1:0]              acc;
    logic [PIECE_W-1:0]            p;

    wcol = signed'({2'b00, cfg.column_bits}) - signed'({4'b0000, cfg.column_low_bits});
    wid  = '0;
    wid[P_CHAN] = {2'b00, cfg.channel_bits};
    wid[P_RANK] = {2'b00, cfg.rank_bits};

    if (cfg.scheme_select == SCHEME_SPLIT) begin
      wid[P_BANK_LO] = WID_W'(1);
      wid[P_BANK_HI] = clamp_width(signed'({4'b0000, cfg.bank_bits}) - OFF_W'(1));
      wid[P_ROW_LO]  = WID_W'(4);
      wid[P_ROW_HI]  = clamp_width(signed'({2'b00, cfg.row_bits}) - OFF_W'(4));
      wid[P_COL_LO]  = WID_W'(6);
      wid[P_COL_MID] = WID_W'(1);
      wid[P_COL_HI]  = clamp_width(wcol - OFF_W'(7));
    end else begin
      wid[P_BANK_LO] = {2'b00, cfg.bank_bits};
      wid[P_ROW_LO]  = cfg.row_bits;
      wid[P_COL_LO]  = clamp_width(wcol);
    end

    plan_next.off = '0;
    acc = '0;
    for (int i = 0; i < NUM_PIECES; i++) begin
      p = PIECE_ORDER[cfg.scheme_select][i];
      plan_next.off[p] = acc;
      acc = acc + {2'b00, wid[p]};
    end
    plan_next.wid   = wid;
    plan_next.align = {1'b0, cfg.byte_offset_bits} + {1'b0, cfg.column_low_bits};
  end

  always_ff @(posedge clk) begin
    plan <= plan_next;
  end

endmodule

@@ tb/sv/dram_address_mapper_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dram_address_mapper_core_test
// Self-checking bench for the DRAM address mapper. A clocked driver sends
// addresses from a pending queue and a clocked monitor compares each mapped
// result with a prediction made when the request was accepted. Mapping
// settings are changed only while the pipeline is empty, and both sides of
// the pipe stall at random except in the last of three random phases.
// ----------------------------------------------------------------------------
module dram_address_mapper_core_test;

  import dam_pkg::*;

  // Fields of a mapped address, as indexes into the predictor's field array
  typedef enum logic [2:0] {
    FLD_CHAN = 3'd0,
    FLD_RANK = 3'd1,
    FLD_BANK = 3'd2,
    FLD_ROW  = 3'd3,
    FLD_COL  = 3'd4
  } field_t;

  // Plain mapping orders, named from the low address end upward
  typedef enum logic [2:0] {
    ORDER_BK_CO_RO_RK_CH = 3'd0,
    ORDER_RK_BK_CO_RO_CH = 3'd1,
    ORDER_RO_CO_BK_RK_CH = 3'd2,
    ORDER_CO_RO_BK_RK_CH = 3'd3,
    ORDER_BK_RK_CO_RO_CH = 3'd4,
    ORDER_CO_RK_BK_RO_CH = 3'd5,
    ORDER_CH_BK_RK_CO_RO = 3'd6
  } scheme_t;

  typedef struct packed {
    logic [3:0]  channel;
    logic [3:0]  rank;
    logic [3:0]  bank;
    logic [19:0] row;
    logic [15:0] column;
    logic        unaligned;
  } mapping_t;

  typedef struct packed {
    logic [63:0] address;
    mapping_t    map;
  } expected_map_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write_enable = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [63:0]            physical_address = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [3:0]             channel;
  logic [3:0]             rank;
  logic [3:0]             bank;
  logic [19:0]            row;
  logic [15:0]            column;
  logic                   unaligned;

  cfg_t          cfg_model = CFG_RESET;
  logic [63:0]   pending_addresses[$];
  expected_map_t expected_maps[$];
  int            requests_queued = 0;
  int            requests_accepted = 0;
  int            mismatch_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  logic          req_taken = 1'b0;

  dram_address_mapper_core DUT (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .physical_address (physical_address),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .channel          (channel),
    .rank             (rank),
    .bank             (bank),
    .row              (row),
    .column           (column),
    .unaligned        (unaligned)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // w bits of a starting at bit pos; empty or out-of-range slices read zero
  function automatic logic [63:0] bit_slice(logic [63:0] a, int pos, int w);
    logic [63:0] v;
    if (w <= 0 || pos >= 64) return '0;
    v = a >> pos;
    if (w < 64) v = v & ((64'd1 << w) - 64'd1);
    return v;
  endfunction

  // address bits consumed by a piece of width w
  function automatic int span(int w);
    return (w > 0) ? w : 0;
  endfunction

  // Expected channel/rank/bank/row/column for one address under setting c
  function automatic mapping_t map_address(logic [63:0] addr, cfg_t c);
    logic [63:0] work;
    logic [63:0] fld [5];
    int          wid [5];
    int          pos;
    int          align;
    int          wcol;
    logic [14:0] order;
    field_t      id;
    logic [63:0] c6, b1, c1, r4, b2, rr, cr;
    mapping_t    m;

    align = int'(c.byte_offset_bits) + int'(c.column_low_bits);
    wcol = int'(c.column_bits) - int'(c.column_low_bits);
    m.unaligned = (addr & ((64'd1 << align) - 64'd1)) != 64'd0;
    work = addr >> align;
    pos = 0;
    for (int i = 0; i < 5; i++) fld[i] = '0;

    if (c.scheme_select == SCHEME_SPLIT) begin
      // split interleave: column, bank and row gathered from scattered pieces
      fld[FLD_CHAN] = bit_slice(work, pos, c.channel_bits);
      pos += span(c.channel_bits);
      c6 = bit_slice(work, pos, 6);
      pos += 6;
      fld[FLD_RANK] = bit_slice(work, pos, c.rank_bits);
      pos += span(c.rank_bits);
      b1 = bit_slice(work, pos, 1);
      pos += 1;
      c1 = bit_slice(work, pos, 1);
      pos += 1;
      r4 = bit_slice(work, pos, 4);
      pos += 4;
      b2 = bit_slice(work, pos, int'(c.bank_bits) - 1);
      pos += span(int'(c.bank_bits) - 1);
      rr = bit_slice(work, pos, int'(c.row_bits) - 4);
      pos += span(int'(c.row_bits) - 4);
      cr = bit_slice(work, pos, wcol - 7);
      fld[FLD_BANK] = b1 | (b2 << 1);
      fld[FLD_COL] = c6 | (c1 << 6) | (cr << 7);
      fld[FLD_ROW] = r4 | (rr << 4);
    end else begin
      // plain orders, first field in the low slot
      wid[FLD_CHAN] = int'(c.channel_bits);
      wid[FLD_RANK] = int'(c.rank_bits);
      wid[FLD_BANK] = int'(c.bank_bits);
      wid[FLD_ROW] = int'(c.row_bits);
      wid[FLD_COL] = wcol;
      case (c.scheme_select)
        ORDER_BK_CO_RO_RK_CH: order = {FLD_CHAN, FLD_RANK, FLD_ROW, FLD_COL, FLD_BANK};
        ORDER_RK_BK_CO_RO_CH: order = {FLD_CHAN, FLD_ROW, FLD_COL, FLD_BANK, FLD_RANK};
        ORDER_RO_CO_BK_RK_CH: order = {FLD_CHAN, FLD_RANK, FLD_BANK, FLD_COL, FLD_ROW};
        ORDER_CO_RO_BK_RK_CH: order = {FLD_CHAN, FLD_RANK, FLD_BANK, FLD_ROW, FLD_COL};
        ORDER_BK_RK_CO_RO_CH: order = {FLD_CHAN, FLD_ROW, FLD_COL, FLD_RANK, FLD_BANK};
        ORDER_CO_RK_BK_RO_CH: order = {FLD_CHAN, FLD_ROW, FLD_BANK, FLD_RANK, FLD_COL};
        default:              order = {FLD_ROW, FLD_COL, FLD_RANK, FLD_BANK, FLD_CHAN};
      endcase
      for (int slot = 0; slot < 5; slot++) begin
        id = field_t'(order[3*slot +: 3]);
        fld[id] = bit_slice(work, pos, wid[id]);
        pos += span(wid[id]);
      end
    end

    m.channel = fld[FLD_CHAN][3:0];
    m.rank = fld[FLD_RANK][3:0];
    m.bank = fld[FLD_BANK][3:0];
    m.row = fld[FLD_ROW][19:0];
    m.column = fld[FLD_COL][15:0];
    return m;
  endfunction

  // Request driver: hold until accepted, then maybe idle, then next address
  always @(negedge clk) begin : drive_requests
    logic [63:0] next_address;
    if (!in_valid || req_taken) begin
      if (!rst && pending_addresses.size() != 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        next_address = pending_addresses.pop_front();
        in_valid <= 1'b1;
        physical_address <= next_address;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure
  always @(negedge clk) begin : drive_out_ready
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: check results against oldest expectation, predict on accept
  always @(posedge clk) begin : check_results
    mapping_t      got;
    expected_map_t want;
    req_taken = !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      got = {channel, rank, bank, row, column, unaligned};
      if (expected_maps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: ch %0d rk %0d bk %0d row %0h col %0h un %0b",
                   got.channel, got.rank, got.bank, got.row, got.column, got.unaligned);
      end else begin
        want = expected_maps.pop_front();
        if (got !== want.map) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch for address %h", want.address);
            $display("  expected: ch %0d rk %0d bk %0d row %0h col %0h un %0b",
                     want.map.channel, want.map.rank, want.map.bank, want.map.row,
                     want.map.column, want.map.unaligned);
            $display("  actual:   ch %0d rk %0d bk %0d row %0h col %0h un %0b",
                     got.channel, got.rank, got.bank, got.row, got.column, got.unaligned);
          end
        end
      end
    end
    if (req_taken) begin
      want.address = physical_address;
      want.map = map_address(physical_address, cfg_model);
      expected_maps.push_back(want);
      requests_accepted++;
    end
  end

  task automatic send_address(logic [63:0] addr);
    pending_addresses.push_back(addr);
    requests_queued++;
  endtask

  // wait until every queued request is accepted and answered
  task automatic drain();
    while (requests_accepted < requests_queued || expected_maps.size() != 0)
      @(negedge clk);
  endtask

  // One register write; spare data bits of 3-bit registers must be dropped
  task automatic write_register(cfg_reg_t idx, int value);
    logic [CFG_DATA_W-1:0] data;
    data = value[CFG_DATA_W-1:0];
    if (idx != REG_ROW_BITS && idx != REG_COLUMN_BITS) data[4:3] = 2'($urandom_range(3));
    @(negedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_SCHEME_SELECT:    cfg_model.scheme_select = data[2:0];
      REG_CHANNEL_BITS:     cfg_model.channel_bits = data[2:0];
      REG_RANK_BITS:        cfg_model.rank_bits = data[2:0];
      REG_BANK_BITS:        cfg_model.bank_bits = data[2:0];
      REG_ROW_BITS:         cfg_model.row_bits = data;
      REG_COLUMN_BITS:      cfg_model.column_bits = data;
      REG_BYTE_OFFSET_BITS: cfg_model.byte_offset_bits = data[2:0];
      default:              cfg_model.column_low_bits = data[2:0];
    endcase
  endtask

  // Load a whole mapping setting once the pipe is empty
  task automatic apply_setting(cfg_t s);
    drain();
    repeat (4) @(negedge clk);
    write_register(REG_SCHEME_SELECT, s.scheme_select);
    write_register(REG_CHANNEL_BITS, s.channel_bits);
    write_register(REG_RANK_BITS, s.rank_bits);
    write_register(REG_BANK_BITS, s.bank_bits);
    write_register(REG_ROW_BITS, s.row_bits);
    write_register(REG_COLUMN_BITS, s.column_bits);
    write_register(REG_BYTE_OFFSET_BITS, s.byte_offset_bits);
    write_register(REG_COLUMN_LOW_BITS, s.column_low_bits);
    @(negedge clk);
    cfg_write_enable <= 1'b0;
    // writes reach the mapping through the registered plan
    @(negedge clk);
  endtask

  function automatic cfg_t widest_setting(logic [2:0] scheme);
    cfg_t s;
    s = '{scheme_select: scheme, channel_bits: 3'd4, rank_bits: 3'd4, bank_bits: 3'd4,
          row_bits: 5'd20, column_bits: 5'd16, byte_offset_bits: 3'd4,
          column_low_bits: 3'd6};
    return s;
  endfunction

  function automatic cfg_t random_setting();
    cfg_t s;
    s.scheme_select = 3'($urandom_range(7));
    s.channel_bits = 3'($urandom_range(4));
    s.rank_bits = 3'($urandom_range(4));
    s.bank_bits = 3'($urandom_range(4));
    s.row_bits = 5'($urandom_range(20));
    s.column_bits = 5'($urandom_range(16));
    s.byte_offset_bits = 3'($urandom_range(4));
    s.column_low_bits = 3'($urandom_range(6));
    return s;
  endfunction

  // Random full-range addresses mixed with aligned, small, sparse and all-ones or all-zero ones
  function automatic logic [63:0] random_address(cfg_t c);
    logic [63:0] a;
    int          align;
    a = {$urandom, $urandom};
    align = int'(c.byte_offset_bits) + int'(c.column_low_bits);
    case ($urandom_range(9))
      4, 5, 6: a = a & ~((64'd1 << align) - 64'd1);
      7:       a = {48'd0, a[15:0]};
      8:       a = 64'd1 << $urandom_range(63);
      9:       a = a[0] ? '1 : '0;
      default: ;
    endcase
    return a;
  endfunction

  // Main sequence: reset, directed cases, then random settings per idle phase
  initial begin : run_test
    cfg_t setting;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 27;
    recv_idle_pct = 46;

    // reset setting, no writes yet
    send_address(64'd0);
    send_address('1);
    send_address(64'h3F);
    send_address(64'h40);

    // widest fields under every scheme
    for (int s = 0; s < 8; s++) begin
      apply_setting(widest_setting(3'(s)));
      send_address('1);
      send_address(64'h0123_4567_89AB_CDEF);
    end

    // all widths zero in split mode: low bank bit still taken
    setting = '0;
    setting.scheme_select = SCHEME_SPLIT;
    apply_setting(setting);
    send_address('1);

    // column narrower than the burst: negative column width
    setting = random_setting();
    setting.scheme_select = SCHEME_SPLIT;
    setting.column_bits = 5'd2;
    setting.column_low_bits = 3'd6;
    apply_setting(setting);
    send_address('1);
    setting.scheme_select = ORDER_CO_RO_BK_RK_CH;
    setting.column_bits = 5'd0;
    apply_setting(setting);
    send_address('1);

    // random part, three phases: two with idling, the last without
    for (int phase = 0; phase < 3; phase++) begin
      drain();
      case (phase)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 46;
        end
        1: begin
          send_idle_pct = 46;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int k = 0; k < 12; k++) begin
        if (k == 0) begin
          setting = widest_setting(3'($urandom_range(7)));
        end else if (k == 1) begin
          setting = '0;
          setting.scheme_select = 3'($urandom_range(7));
        end else begin
          setting = random_setting();
        end
        apply_setting(setting);
        for (int n = 0; n < 24; n++) send_address(random_address(cfg_model));
      end
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && expected_maps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/dam_pkg.sv
hw/rtl/dam_plan.sv
hw/rtl/dram_address_mapper_core.sv
tb/sv/dram_address_mapper_core_test.sv
